// ===== rtl/core/hse_pkg.sv =====
// Shared types and codes for the heap sort engine.
// Holds the controller-to-datapath command and status structs; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hse_pkg;

    // Read address source for the heap store.
    typedef logic [2:0] t_rd_sel;
    localparam t_rd_sel RD_NODE  = 3'd0;
    localparam t_rd_sel RD_LEFT  = 3'd1;
    localparam t_rd_sel RD_RIGHT = 3'd2;
    localparam t_rd_sel RD_ZERO  = 3'd3;
    localparam t_rd_sel RD_IDX   = 3'd4;
    localparam t_rd_sel RD_IDXM1 = 3'd5;
    localparam t_rd_sel RD_K     = 3'd6;

    // Write source and address for the heap store.
    typedef logic [2:0] t_wr_sel;
    localparam t_wr_sel WR_NONE   = 3'd0;
    localparam t_wr_sel WR_LOAD   = 3'd1;
    localparam t_wr_sel WR_VAL    = 3'd2;
    localparam t_wr_sel WR_BIG    = 3'd3;
    localparam t_wr_sel WR_LV_IDX = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        t_rd_sel rd_sel;
        t_wr_sel wr_sel;
        logic    clr_batch;
        logic    idx_build;
        logic    idx_sort;
        logic    idx_dec;
        logic    node_from_idx;
        logic    node_root;
        logic    node_to_big;
        logic    val_from_rd;
        logic    lv_from_rd;
        logic    use_right;
        logic    k_clr;
        logic    k_inc;
        logic    out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic count_lt2;
        logic left_out;
        logic right_out;
        logic stop;
        logic idx_gt1;
        logic out_last;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/core/heap_sort_engine_core.sv =====
// Heap sort engine: loads one sample per beat, heapsorts in place, streams results ascending.
// After the final beat, each sift step runs as read left, read right, then compare and write,
// on a store with one read and one write a cycle. Each result beat is read from the store,
// loaded into the result register and held on offer until the consumer takes it.
// Reset clears the fill count, drop flag and sequencer; the heap store needs no clearing pass.
// Depends on hse_pkg, hse_ctrl and hse_datapath.
`timescale 1ns / 1ps
`default_nettype none

module heap_sort_engine_core
    import hse_pkg::*;
#(
    parameter int STORE_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [VALUE_WIDTH-1:0] i_sample_value,
    input  logic                          i_final_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [VALUE_WIDTH-1:0] o_sorted_value,
    output logic                          o_last_result,
    output logic                          o_overflow_flag
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer.
    hse_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_final_item (i_final_item),
        .i_out_stall  (i_out_stall),
        .i_sts        (sts),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .o_cmd        (cmd)
    );

    // Heap store and compare datapath.
    hse_datapath #(
        .STORE_DEPTH (STORE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_sample_value  (i_sample_value),
        .o_sts           (sts),
        .o_sorted_value  (o_sorted_value),
        .o_last_result   (o_last_result),
        .o_overflow_flag (o_overflow_flag)
    );

    // Input is never taken while a result is on offer.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !o_out_valid)
        else $error("input open while a result is pending");

    // The final result beat of a batch reopens the input.
    a_last_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last_result) |=> !o_in_stall)
        else $error("input not reopened after the final result");

    // A result beat that is not final keeps the input closed.
    a_mid_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_result) |=> o_in_stall)
        else $error("input reopened in the middle of a batch");

endmodule

`default_nettype wire

// ===== rtl/core/hse_datapath.sv =====
// Datapath of the heap sort engine: heap store memory, index registers, compare.
// Depends on hse_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module hse_datapath
    import hse_pkg::*;
#(
    parameter int STORE_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    input  logic signed [VALUE_WIDTH-1:0] i_sample_value,
    output t_dp_sts                       o_sts,
    output logic signed [VALUE_WIDTH-1:0] o_sorted_value,
    output logic                          o_last_result,
    output logic                          o_overflow_flag
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);

    // Heap store, one write and one registered read per cycle.
    logic signed [VALUE_WIDTH-1:0] r_mem [STORE_DEPTH];
    logic signed [VALUE_WIDTH-1:0] r_rdata;

    logic [CW-1:0] r_count;
    logic          r_dropped;
    logic [CW-1:0] r_size;
    logic [AW-1:0] r_node;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] r_k;
    logic signed [VALUE_WIDTH-1:0] r_val;
    logic signed [VALUE_WIDTH-1:0] r_lv;
    logic signed [VALUE_WIDTH-1:0] r_sorted;
    logic          r_last;
    logic          r_ovf;

    logic [AW:0]   left_w;
    logic [AW+1:0] right_w;
    logic [AW+1:0] size_x;
    logic [AW-1:0] idx_m1;
    logic          not_full;
    logic          pick_right;
    logic signed [VALUE_WIDTH-1:0] big_v;
    logic [AW-1:0] big_idx;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic signed [VALUE_WIDTH-1:0] wr_data;
    logic          wr_en;

    // Child indices of the node being sifted.
    assign left_w   = {r_node, 1'b1};
    assign right_w  = (AW+2)'(left_w) + (AW+2)'(1);
    assign size_x   = (AW+2)'(r_size);
    assign idx_m1   = r_idx - AW'(1);
    assign not_full = r_count < CW'(STORE_DEPTH);

    // Larger child: ties keep the left one.
    assign pick_right = i_cmd.use_right && (r_lv < r_rdata);
    assign big_v      = pick_right ? r_rdata : (i_cmd.use_right ? r_lv : r_rdata);
    assign big_idx    = pick_right ? right_w[AW-1:0] : left_w[AW-1:0];

    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.count_lt2  = (r_count < CW'(2));
    assign o_sts.left_out   = ((AW+2)'(left_w) >= size_x);
    assign o_sts.right_out  = (right_w >= size_x);
    assign o_sts.stop       = (r_val >= big_v);
    assign o_sts.idx_gt1    = (r_idx > AW'(1));
    assign o_sts.out_last   = r_last;

    // Read address select.
    always_comb begin
        case (i_cmd.rd_sel)
            RD_NODE:  rd_addr = r_node;
            RD_LEFT:  rd_addr = left_w[AW-1:0];
            RD_RIGHT: rd_addr = right_w[AW-1:0];
            RD_ZERO:  rd_addr = '0;
            RD_IDX:   rd_addr = r_idx;
            RD_IDXM1: rd_addr = idx_m1;
            RD_K:     rd_addr = r_k;
            default:  rd_addr = '0;
        endcase
    end

    // Write address and data select.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_node;
        wr_data = r_val;
        case (i_cmd.wr_sel)
            WR_LOAD: begin
                wr_en   = not_full;
                wr_addr = r_count[AW-1:0];
                wr_data = i_sample_value;
            end
            WR_VAL: begin
                wr_en = 1'b1;
            end
            WR_BIG: begin
                wr_en   = 1'b1;
                wr_data = big_v;
            end
            WR_LV_IDX: begin
                wr_en   = 1'b1;
                wr_addr = r_idx;
                wr_data = r_lv;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Heap store.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // Batch fill count and drop flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else if (i_cmd.clr_batch) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else if (i_cmd.wr_sel == WR_LOAD) begin
            if (not_full) begin
                r_count <= r_count + CW'(1);
            end else begin
                r_dropped <= 1'b1;
            end
        end
    end

    // Loop index, sift node and heap size.
    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_build) begin
            r_idx <= AW'(r_count >> 1);
        end else if (i_cmd.idx_sort) begin
            r_idx <= AW'(r_count - CW'(1));
        end else if (i_cmd.idx_dec) begin
            r_idx <= idx_m1;
        end
        if (i_cmd.node_from_idx) begin
            r_node <= idx_m1;
            r_size <= r_count;
        end else if (i_cmd.node_root) begin
            r_node <= '0;
            r_size <= CW'(r_idx);
        end else if (i_cmd.node_to_big) begin
            r_node <= big_idx;
        end
        if (i_cmd.val_from_rd) begin
            r_val <= r_rdata;
        end
        if (i_cmd.lv_from_rd) begin
            r_lv <= r_rdata;
        end
    end

    // Output counter and result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.k_clr) begin
            r_k <= '0;
        end else if (i_cmd.k_inc) begin
            r_k <= r_k + AW'(1);
        end
        if (i_cmd.out_load) begin
            r_sorted <= r_rdata;
            r_last   <= ((CW'(r_k) + CW'(1)) == r_count);
            r_ovf    <= r_dropped;
        end
    end

    assign o_sorted_value  = r_sorted;
    assign o_last_result   = r_last;
    assign o_overflow_flag = r_ovf;

endmodule

`default_nettype wire

// ===== rtl/core/hse_ctrl.sv =====
// Controller of the heap sort engine: load, heap build, sort-down and output sequencing.
// Depends on hse_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module hse_ctrl
    import hse_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_final_item,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    localparam logic [3:0] S_LOAD     = 4'd0;
    localparam logic [3:0] S_START    = 4'd1;
    localparam logic [3:0] S_BLD_RD   = 4'd2;
    localparam logic [3:0] S_BLD_V    = 4'd3;
    localparam logic [3:0] S_SRT_RD0  = 4'd4;
    localparam logic [3:0] S_SRT_RDI  = 4'd5;
    localparam logic [3:0] S_SRT_WR   = 4'd6;
    localparam logic [3:0] S_SIFT_L   = 4'd7;
    localparam logic [3:0] S_SIFT_R   = 4'd8;
    localparam logic [3:0] S_SIFT_C   = 4'd9;
    localparam logic [3:0] S_OUT_RD   = 4'd10;
    localparam logic [3:0] S_OUT_LD   = 4'd11;
    localparam logic [3:0] S_OUT_WAIT = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_sort_phase;
    logic       n_sort_phase;
    logic       in_beat;
    logic       out_beat;
    logic       sift_done;

    assign in_beat     = i_in_valid && (r_state == S_LOAD);
    assign out_beat    = (r_state == S_OUT_WAIT) && !i_out_stall;
    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = (r_state == S_OUT_WAIT);

    // Next state and datapath commands.
    always_comb begin
        n_state      = r_state;
        n_sort_phase = r_sort_phase;
        sift_done    = 1'b0;
        o_cmd        = '0;
        o_cmd.rd_sel = RD_NODE;
        o_cmd.wr_sel = WR_NONE;
        case (r_state)
            S_LOAD: begin
                if (in_beat) begin
                    o_cmd.wr_sel = WR_LOAD;
                    if (i_final_item) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                if (i_sts.count_zero) begin
                    o_cmd.clr_batch = 1'b1;
                    n_state         = S_LOAD;
                end else if (i_sts.count_lt2) begin
                    o_cmd.k_clr = 1'b1;
                    n_state     = S_OUT_RD;
                end else begin
                    o_cmd.idx_build = 1'b1;
                    n_sort_phase    = 1'b0;
                    n_state         = S_BLD_RD;
                end
            end
            S_BLD_RD: begin
                o_cmd.rd_sel        = RD_IDXM1;
                o_cmd.node_from_idx = 1'b1;
                n_state             = S_BLD_V;
            end
            S_BLD_V: begin
                o_cmd.val_from_rd = 1'b1;
                n_state           = S_SIFT_L;
            end
            S_SRT_RD0: begin
                o_cmd.rd_sel = RD_ZERO;
                n_state      = S_SRT_RDI;
            end
            S_SRT_RDI: begin
                o_cmd.lv_from_rd = 1'b1;
                o_cmd.rd_sel     = RD_IDX;
                n_state          = S_SRT_WR;
            end
            S_SRT_WR: begin
                // The old root goes to the end of the heap; the last entry is sifted from the root.
                o_cmd.val_from_rd = 1'b1;
                o_cmd.wr_sel      = WR_LV_IDX;
                o_cmd.node_root   = 1'b1;
                n_state           = S_SIFT_L;
            end
            S_SIFT_L: begin
                o_cmd.rd_sel = RD_LEFT;
                if (i_sts.left_out) begin
                    o_cmd.wr_sel = WR_VAL;
                    sift_done    = 1'b1;
                end else begin
                    n_state = S_SIFT_R;
                end
            end
            S_SIFT_R: begin
                o_cmd.lv_from_rd = 1'b1;
                o_cmd.rd_sel     = RD_RIGHT;
                if (!i_sts.right_out) begin
                    n_state = S_SIFT_C;
                end else if (i_sts.stop) begin
                    o_cmd.wr_sel = WR_VAL;
                    sift_done    = 1'b1;
                end else begin
                    o_cmd.wr_sel      = WR_BIG;
                    o_cmd.node_to_big = 1'b1;
                    n_state           = S_SIFT_L;
                end
            end
            S_SIFT_C: begin
                o_cmd.use_right = 1'b1;
                if (i_sts.stop) begin
                    o_cmd.wr_sel = WR_VAL;
                    sift_done    = 1'b1;
                end else begin
                    o_cmd.wr_sel      = WR_BIG;
                    o_cmd.node_to_big = 1'b1;
                    n_state           = S_SIFT_L;
                end
            end
            S_OUT_RD: begin
                o_cmd.rd_sel = RD_K;
                n_state      = S_OUT_LD;
            end
            S_OUT_LD: begin
                o_cmd.out_load = 1'b1;
                n_state        = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (out_beat) begin
                    if (i_sts.out_last) begin
                        o_cmd.clr_batch = 1'b1;
                        n_state         = S_LOAD;
                    end else begin
                        o_cmd.k_inc = 1'b1;
                        n_state     = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase

        // End of one sift: step the build or sort-down loop.
        if (sift_done) begin
            if (i_sts.idx_gt1) begin
                o_cmd.idx_dec = 1'b1;
                n_state       = r_sort_phase ? S_SRT_RD0 : S_BLD_RD;
            end else if (!r_sort_phase) begin
                o_cmd.idx_sort = 1'b1;
                n_sort_phase   = 1'b1;
                n_state        = S_SRT_RD0;
            end else begin
                o_cmd.k_clr = 1'b1;
                n_state     = S_OUT_RD;
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_sort_phase <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sort_phase <= n_sort_phase;
        end
    end

endmodule

`default_nettype wire
